// ===== rtl/core/spt_pkg.sv =====
// shared types and constants for the stream prefetch tracker
// no dependencies; imported by every module of the block
package spt_pkg;

   localparam int FIELD_W   = 48;   // width of address fields on the ports
   localparam int DEG_W     = 5;    // width of the degree register
   localparam int MAX_RUN   = 16;   // longest prefetch run per access
   localparam int DEG_RESET = 5;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_UP   = 2'd1,
      DIR_DOWN = 2'd2
   } dir_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_UPDATE
   } state_type;

   // shift control broadcast to the tracker cells
   typedef struct packed {
      logic write;   // update cycle that moves a tracker to the head
      logic all;     // shift every cell (new page)
   } cell_ctl_type;

   // start of a prefetch run
   typedef struct packed {
      logic start;
      logic up;
   } run_ctl_type;

endpackage

// ===== rtl/core/spt_cell.sv =====
// one tracker cell of the recency chain: page tag, last offset, last direction
// depends on spt_pkg; instantiated in a row by stream_prefetch_tracker_unit
module spt_cell #(
   parameter int PW    = 36,
   parameter int OFF_W = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  spt_pkg::cell_ctl_type ctl,
   input  logic [PW-1:0]        cmp_page,
   input  logic                 in_valid,
   input  logic [PW-1:0]        in_page,
   input  logic [OFF_W-1:0]     in_offset,
   input  spt_pkg::dir_type     in_dir,
   output logic                 out_valid,
   output logic [PW-1:0]        out_page,
   output logic [OFF_W-1:0]     out_offset,
   output spt_pkg::dir_type     out_dir,
   input  logic                 hit_above_in,
   output logic                 hit_above_out,
   input  logic [OFF_W-1:0]     match_off_in,
   input  spt_pkg::dir_type     match_dir_in,
   output logic [OFF_W-1:0]     match_off_out,
   output spt_pkg::dir_type     match_dir_out
);
   import spt_pkg::*;

   logic             valid_ff;
   logic [PW-1:0]    page_ff;
   logic [OFF_W-1:0] offset_ff;
   dir_type          dir_ff;
   logic             hit_ff;
   logic             hit_in;
   logic             shift;

   assign hit_in = valid_ff && (page_ff == cmp_page);
   // a cell moves when it or any older cell holds the hit, or on a new page
   assign shift  = ctl.write && (ctl.all || hit_ff || hit_above_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         hit_ff <= hit_in;
         if (shift) begin
            valid_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         page_ff   <= in_page;
         offset_ff <= in_offset;
         dir_ff    <= in_dir;
      end
   end

   assign out_valid     = valid_ff;
   assign out_page      = page_ff;
   assign out_offset    = offset_ff;
   assign out_dir       = dir_ff;
   assign hit_above_out = hit_above_in || hit_ff;
   assign match_off_out = match_off_in | (hit_ff ? offset_ff : '0);
   assign match_dir_out = dir_type'(match_dir_in | (hit_ff ? dir_ff : DIR_NONE));

endmodule

// ===== rtl/core/spt_run.sv =====
// prefetch run generator with output register
// depends on spt_pkg; driven by stream_prefetch_tracker_unit
module spt_run #(
   parameter int PW         = 36,
   parameter int OFF_W      = 6,
   parameter int BLOCK_BITS = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  spt_pkg::run_ctl_type          ctl,
   input  logic [PW-1:0]                 start_page,
   input  logic [OFF_W-1:0]              start_offset,
   input  logic [spt_pkg::DEG_W-1:0]     start_count,
   output logic                          busy,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [spt_pkg::FIELD_W-1:0]   rsp_prefetch_address,
   output logic                          rsp_last_of_run
);
   import spt_pkg::*;

   logic [PW-1:0]      page_ff;
   logic [OFF_W-1:0]   off_ff;
   logic [OFF_W-1:0]   off_in;
   logic               up_ff;
   logic [DEG_W-1:0]   left_ff;
   logic               valid_ff;
   logic [FIELD_W-1:0] addr_ff;
   logic               last_ff;
   logic               active;
   logic               load;

   assign active = (left_ff != '0);
   assign load   = active && (!valid_ff || rsp_ready);
   assign off_in = up_ff ? off_ff + OFF_W'(1) : off_ff - OFF_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (ctl.start) begin
            left_ff <= start_count;
         end else if (load) begin
            left_ff <= left_ff - DEG_W'(1);
         end
         if (load) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         page_ff <= start_page;
         off_ff  <= start_offset;
         up_ff   <= ctl.up;
      end else if (load) begin
         off_ff <= off_in;
      end
      if (load) begin
         addr_ff <= FIELD_W'({page_ff, off_in, {BLOCK_BITS{1'b0}}});
         last_ff <= (left_ff == DEG_W'(1));
      end
   end

   assign busy                 = active;
   assign rsp_valid            = valid_ff;
   assign rsp_prefetch_address = addr_ff;
   assign rsp_last_of_run      = last_ff;

endmodule

// ===== rtl/core/stream_prefetch_tracker_unit.sv =====
// top level of the per-page stream prefetch tracker
// depends on spt_pkg, spt_cell and spt_run
//
// usage:
//  - req channel (valid/ready) carries one demand access address per transaction
//  - rsp channel (valid/ready) returns the prefetch block addresses, one per
//    transaction, with last_of_run on the final address caused by an access
//  - csr port writes the prefetch degree (reset value 5, values above 16 act
//    as 16) with no wait; write it only while the block is idle
//  - each access goes through capture, tag compare in every cell of the
//    tracker chain, then the chain update; an access that prefetches n blocks
//    starts its run in the update, gives the first address through the output
//    register, then one address per cycle while the receiver takes them
//  - the recency chain is the limit: one access is looked up and applied at a
//    time, and a new access waits until the previous run is fully generated
//  - a stalled receiver holds the output register; the run pauses with it,
//    and the next access can be taken while the last address still waits
//  - reset empties every tracker and drops any pending prefetch
module stream_prefetch_tracker_unit #(
   parameter int NUM_TRACKERS = 64,
   parameter int PAGE_BITS    = 12,
   parameter int BLOCK_BITS   = 6,
   parameter int ADDR_BITS    = 48
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [spt_pkg::FIELD_W-1:0]   req_access_address,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [spt_pkg::FIELD_W-1:0]   rsp_prefetch_address,
   output logic                          rsp_last_of_run,
   input  logic                          csr_write_enable,
   input  logic [spt_pkg::DEG_W-1:0]     csr_write_data
);
   import spt_pkg::*;

   // addresses above the field width never reach the table
   localparam int EFF_BITS = (ADDR_BITS < FIELD_W) ? ADDR_BITS : FIELD_W;
   localparam int PW       = EFF_BITS - PAGE_BITS;
   localparam int OFF_W    = PAGE_BITS - BLOCK_BITS;
   localparam int CMP_W    = (OFF_W > DEG_W) ? OFF_W : DEG_W;

   state_type        state_ff;
   state_type        state_in;
   logic [PW-1:0]    page_ff;
   logic [OFF_W-1:0] offset_ff;
   logic [DEG_W-1:0] degree_ff;

   logic             run_busy;
   cell_ctl_type     cell_ctl;
   run_ctl_type      run_ctl;

   // tracker chain wiring: entries flow toward higher cells (older),
   // hit and match data flow toward cell 0 (most recent)
   logic             cell_valid [NUM_TRACKERS];
   logic [PW-1:0]    cell_page  [NUM_TRACKERS];
   logic [OFF_W-1:0] cell_off   [NUM_TRACKERS];
   dir_type          cell_dir   [NUM_TRACKERS];
   logic             hit_chain  [NUM_TRACKERS+1];
   logic [OFF_W-1:0] match_off  [NUM_TRACKERS+1];
   dir_type          match_dir  [NUM_TRACKERS+1];

   // update decision
   logic             found;
   logic             same_off;
   logic             go_up;
   dir_type          new_dir;
   logic [DEG_W-1:0] deg_sat;
   logic [OFF_W-1:0] room;
   logic [DEG_W-1:0] run_count;

   logic             req_fire;
   assign req_fire = req_valid && req_ready;

   // degree register
   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= DEG_W'(DEG_RESET);
      end else if (csr_write_enable) begin
         degree_ff <= csr_write_data;
      end
   end

   // captured access, split into page tag and block offset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         page_ff   <= req_access_address[EFF_BITS-1:PAGE_BITS];
         offset_ff <= req_access_address[PAGE_BITS-1:BLOCK_BITS];
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK:   state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // result of the tag compare, gathered along the chain
   assign found    = hit_chain[0];
   assign same_off = (match_off[0] == offset_ff);
   assign go_up    = (offset_ff > match_off[0]);
   assign new_dir  = !found ? DIR_NONE : (go_up ? DIR_UP : DIR_DOWN);

   // run length: degree capped at the run limit and at the page edge
   assign deg_sat   = (degree_ff > DEG_W'(MAX_RUN)) ? DEG_W'(MAX_RUN) : degree_ff;
   assign room      = go_up ? ~offset_ff : offset_ff;
   assign run_count = (CMP_W'(room) < CMP_W'(deg_sat)) ? DEG_W'(room) : deg_sat;

   always_comb begin
      req_ready      = 1'b0;
      cell_ctl.write = 1'b0;
      cell_ctl.all   = 1'b0;
      run_ctl.start  = 1'b0;
      run_ctl.up     = go_up;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !run_busy;
         end
         ST_LOOK: begin
         end
         ST_UPDATE: begin
            // new page: push at the head, oldest tracker falls off the end;
            // hit at a new offset: move the tracker to the head
            cell_ctl.write = !found || !same_off;
            cell_ctl.all   = !found;
            run_ctl.start  = found && !same_off && (new_dir == match_dir[0])
                             && (run_count != '0);
         end
         default: begin
         end
      endcase
   end

   assign hit_chain[NUM_TRACKERS] = 1'b0;
   assign match_off[NUM_TRACKERS] = '0;
   assign match_dir[NUM_TRACKERS] = DIR_NONE;

   for (genvar i = 0; i < NUM_TRACKERS; i++) begin : g_cell
      logic             in_valid;
      logic [PW-1:0]    in_page;
      logic [OFF_W-1:0] in_offset;
      dir_type          in_dir;

      if (i == 0) begin : g_head
         // head cell takes the freshly touched tracker
         assign in_valid  = 1'b1;
         assign in_page   = page_ff;
         assign in_offset = offset_ff;
         assign in_dir    = new_dir;
      end else begin : g_body
         assign in_valid  = cell_valid[i-1];
         assign in_page   = cell_page[i-1];
         assign in_offset = cell_off[i-1];
         assign in_dir    = cell_dir[i-1];
      end

      spt_cell #(
         .PW    (PW),
         .OFF_W (OFF_W)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctl           (cell_ctl),
         .cmp_page      (page_ff),
         .in_valid      (in_valid),
         .in_page       (in_page),
         .in_offset     (in_offset),
         .in_dir        (in_dir),
         .out_valid     (cell_valid[i]),
         .out_page      (cell_page[i]),
         .out_offset    (cell_off[i]),
         .out_dir       (cell_dir[i]),
         .hit_above_in  (hit_chain[i+1]),
         .hit_above_out (hit_chain[i]),
         .match_off_in  (match_off[i+1]),
         .match_dir_in  (match_dir[i+1]),
         .match_off_out (match_off[i]),
         .match_dir_out (match_dir[i])
      );
   end

   spt_run #(
      .PW         (PW),
      .OFF_W      (OFF_W),
      .BLOCK_BITS (BLOCK_BITS)
   ) u_run (
      .clock                (clock),
      .reset                (reset),
      .ctl                  (run_ctl),
      .start_page           (page_ff),
      .start_offset         (offset_ff),
      .start_count          (run_count),
      .busy                 (run_busy),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_prefetch_address (rsp_prefetch_address),
      .rsp_last_of_run      (rsp_last_of_run)
   );

endmodule

// ===== rtl/core/spt_checker.sv =====
// port-level checks for stream_prefetch_tracker_unit
// depends on spt_pkg; bound to the top level below
module spt_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [spt_pkg::FIELD_W-1:0] rsp_prefetch_address,
   input logic                        rsp_last_of_run
);
   import spt_pkg::*;

   // nothing is pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // an accepted access blocks the next one during lookup
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req_ready high during lookup");

   // a run in progress holds off new accesses
   a_run_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_of_run) |-> !req_ready)
      else $error("access taken while a run is unfinished");

   // a run continues without a gap once an address is taken
   a_run_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_of_run) |=> rsp_valid)
      else $error("gap inside a prefetch run");

   // a stalled address holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_prefetch_address)))
      else $error("stalled prefetch address changed");

endmodule

bind stream_prefetch_tracker_unit spt_checker u_spt_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_ready            (req_ready),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_prefetch_address (rsp_prefetch_address),
   .rsp_last_of_run      (rsp_last_of_run)
);

// ===== tb/tb_stream_prefetch_tracker_unit.sv =====
// self-checking testbench for stream_prefetch_tracker_unit: directed table, then random streams
// depends on spt_pkg and the rtl of the block; predicts every prefetch run in the bench itself
module tb_stream_prefetch_tracker_unit;
   import spt_pkg::*;

   localparam int NUM_TRACKERS    = 64;
   localparam int PAGE_BITS       = 12;
   localparam int BLOCK_BITS      = 6;
   localparam int ADDR_BITS       = 48;
   localparam int PAGE_W          = FIELD_W - PAGE_BITS;
   localparam int OFF_W           = PAGE_BITS - BLOCK_BITS;
   localparam int BLOCKS_PER_PAGE = 1 << OFF_W;
   localparam int BLOCK_BYTES     = 1 << BLOCK_BITS;

   localparam int HOT_PAGES       = 6;
   localparam int PHASES          = 4;
   localparam int ITEMS_PER_PHASE = 22;
   localparam int SETTLE_CYCLES   = 8;       // margin for an access that is still in lookup or update
   localparam int TAIL_CYCLES     = 20;
   localparam int HOLD_AT         = 40;      // accesses taken before the long receiver stall
   localparam int HOLD_CYCLES     = 300;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int UNTYPED         = -1;      // row result comes from the predictor

   typedef enum logic {ROW_ACCESS, ROW_DEGREE} row_kind_type;

   // one row of the directed table: an access or a degree write
   typedef struct packed {
      row_kind_type       kind;
      logic [FIELD_W-1:0] value;        // access address or degree
      int                 typed_runs;   // number of prefetches, or UNTYPED
      logic [FIELD_W-1:0] first;        // first prefetch address when typed
      dir_type            dir;          // run direction when typed
   } stim_row_type;

   typedef struct packed {
      logic [PAGE_W-1:0] page;
      logic [OFF_W-1:0]  offset;
      dir_type           dir;
   } tracker_type;

   typedef struct packed {
      logic [FIELD_W-1:0] addr;
      logic               last;
   } prefetch_type;

   localparam int NUM_ROWS = 24;

   stim_row_type directed_rows [NUM_ROWS] = '{
      // first page: new tracker, first step, same block, then a run of five upward
      '{ROW_ACCESS, 48'h0000_0000_0000, 0,       48'h0,              DIR_NONE},
      '{ROW_ACCESS, 48'h0000_0000_0040, 0,       48'h0,              DIR_NONE},
      '{ROW_ACCESS, 48'h0000_0000_007F, 0,       48'h0,              DIR_NONE},
      '{ROW_ACCESS, 48'h0000_0000_0080, 5,       48'h0000_0000_00C0, DIR_UP},
      // turn downward, then repeat the direction at the low page edge
      '{ROW_ACCESS, 48'h0000_0000_0040, UNTYPED, 48'h0,              DIR_NONE},
      '{ROW_ACCESS, 48'h0000_0000_0000, 0,       48'h0,              DIR_NONE},
      // top page of the address space, run downward, then up into the high edge
      '{ROW_ACCESS, 48'hFFFF_FFFF_FFFF, 0,       48'h0,              DIR_NONE},
      '{ROW_ACCESS, 48'hFFFF_FFFF_FF80, UNTYPED, 48'h0,              DIR_NONE},
      '{ROW_ACCESS, 48'hFFFF_FFFF_FF40, 5,       48'hFFFF_FFFF_FF00, DIR_DOWN},
      '{ROW_ACCESS, 48'hFFFF_FFFF_FF80, UNTYPED, 48'h0,              DIR_NONE},
      '{ROW_ACCESS, 48'hFFFF_FFFF_FFC0, 0,       48'h0,              DIR_NONE},
      // run cut short by the page end
      '{ROW_ACCESS, 48'h0000_0000_1E80, UNTYPED, 48'h0,              DIR_NONE},
      '{ROW_ACCESS, 48'h0000_0000_1EC0, UNTYPED, 48'h0,              DIR_NONE},
      '{ROW_ACCESS, 48'h0000_0000_1F00, 3,       48'h0000_0000_1F40, DIR_UP},
      // degree zero still updates the tracker but emits nothing
      '{ROW_DEGREE, 48'd0,              UNTYPED, 48'h0,              DIR_NONE},
      '{ROW_ACCESS, 48'h0000_0000_1EC0, UNTYPED, 48'h0,              DIR_NONE},
      '{ROW_ACCESS, 48'h0000_0000_1E80, 0,       48'h0,              DIR_NONE},
      // degree above sixteen saturates
      '{ROW_DEGREE, 48'd31,             UNTYPED, 48'h0,              DIR_NONE},
      '{ROW_ACCESS, 48'h0000_0000_2000, UNTYPED, 48'h0,              DIR_NONE},
      '{ROW_ACCESS, 48'h0000_0000_2040, UNTYPED, 48'h0,              DIR_NONE},
      '{ROW_ACCESS, 48'h0000_0000_2080, 16,      48'h0000_0000_20C0, DIR_UP},
      '{ROW_DEGREE, 48'd16,             UNTYPED, 48'h0,              DIR_NONE},
      '{ROW_ACCESS, 48'h0000_0000_20C0, 16,      48'h0000_0000_2100, DIR_UP},
      // one more plain step keeps the table ending on an access
      '{ROW_ACCESS, 48'h0000_0000_2140, UNTYPED, 48'h0,              DIR_NONE}
   };

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [FIELD_W-1:0]   req_access_address;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [FIELD_W-1:0]   rsp_prefetch_address;
   logic                 rsp_last_of_run;
   logic                 csr_write_enable;
   logic [DEG_W-1:0]     csr_write_data;

   // typed expectation travels with the access it belongs to
   int                   req_typed_runs;
   logic [FIELD_W-1:0]   req_typed_first;
   dir_type              req_typed_dir;

   // predictor state: index 0 of the chain is the least recent tracker
   tracker_type          tracker_chain [$];
   logic [DEG_W-1:0]     degree_setting = DEG_W'(DEG_RESET);
   logic [FIELD_W-1:0]   run_addr [MAX_RUN];
   prefetch_type         pending_prefetches [$];

   int                   fail_count   = 0;
   int                   access_count = 0;
   int                   cycle_count  = 0;
   int                   burst_left   = 0;
   int                   hold_left    = 0;
   int                   stall_cycle  = 0;
   bit                   hold_done    = 1'b0;

   stream_prefetch_tracker_unit #(
      .NUM_TRACKERS (NUM_TRACKERS),
      .PAGE_BITS    (PAGE_BITS),
      .BLOCK_BITS   (BLOCK_BITS),
      .ADDR_BITS    (ADDR_BITS)
   ) DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_access_address   (req_access_address),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_prefetch_address (rsp_prefetch_address),
      .rsp_last_of_run      (rsp_last_of_run),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // applies one access to the tracker chain; fills run_addr and returns the run length
   function automatic int track_access(input logic [FIELD_W-1:0] addr);
      logic [PAGE_W-1:0] page;
      logic [OFF_W-1:0]  offset;
      dir_type           dir;
      tracker_type       entry;
      int                hit;
      int                degree;
      int                room;
      int                run;
      bit                same_dir;
      page   = addr[FIELD_W-1:PAGE_BITS];
      offset = addr[PAGE_BITS-1:BLOCK_BITS];
      hit    = -1;
      for (int i = 0; i < tracker_chain.size(); i++)
         if (tracker_chain[i].page == page) hit = i;
      entry.page   = page;
      entry.offset = offset;
      entry.dir    = DIR_NONE;
      if (hit < 0) begin
         // unknown page: new tracker as most recent, oldest one drops out when full
         if (tracker_chain.size() >= NUM_TRACKERS) tracker_chain.delete(0);
         tracker_chain.insert(tracker_chain.size(), entry);
         return 0;
      end
      // same block again leaves recency alone
      if (offset == tracker_chain[hit].offset) return 0;
      dir      = (offset > tracker_chain[hit].offset) ? DIR_UP : DIR_DOWN;
      same_dir = (dir == tracker_chain[hit].dir);
      tracker_chain.delete(hit);
      entry.dir = dir;
      tracker_chain.insert(tracker_chain.size(), entry);
      if (!same_dir) return 0;
      degree = (degree_setting > MAX_RUN) ? MAX_RUN : int'(degree_setting);
      room   = (dir == DIR_UP) ? BLOCKS_PER_PAGE - 1 - int'(offset) : int'(offset);
      run    = (degree < room) ? degree : room;
      for (int k = 1; k <= run; k++)
         run_addr[k-1] = {page,
                          OFF_W'((dir == DIR_UP) ? int'(offset) + k : int'(offset) - k),
                          {BLOCK_BITS{1'b0}}};
      return run;
   endfunction

   // scoreboard: results are checked before the accepted access is predicted
   always @(posedge clock) begin : scoreboard
      prefetch_type want;
      int           n;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_prefetches.size() == 0) begin
               $error("prefetch_address: nothing expected, got %h", rsp_prefetch_address);
               fail_count++;
            end else begin
               want = pending_prefetches[0];
               pending_prefetches.delete(0);
               if (rsp_prefetch_address !== want.addr) begin
                  $error("prefetch_address: expected %h, got %h",
                         want.addr, rsp_prefetch_address);
                  fail_count++;
               end
               if (rsp_last_of_run !== want.last) begin
                  $error("last_of_run: expected %0b, got %0b", want.last, rsp_last_of_run);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            access_count <= access_count + 1;
            n = track_access(req_access_address);
            if (req_typed_runs == UNTYPED) begin
               for (int i = 0; i < n; i++) begin
                  want.addr = run_addr[i];
                  want.last = (i == n - 1);
                  pending_prefetches.insert(pending_prefetches.size(), want);
               end
            end else begin
               // typed row: the run is read straight off the table
               for (int i = 0; i < req_typed_runs; i++) begin
                  want.addr = (req_typed_dir == DIR_UP)
                            ? req_typed_first + FIELD_W'(i * BLOCK_BYTES)
                            : req_typed_first - FIELD_W'(i * BLOCK_BYTES);
                  want.last = (i == req_typed_runs - 1);
                  pending_prefetches.insert(pending_prefetches.size(), want);
               end
            end
         end
      end
   end

   // receiver: modes picked by stall_cycle[8:7], plus one long stall once traffic is going
   always @(posedge clock) begin
      stall_cycle <= stall_cycle + 1;
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && access_count >= HOLD_AT) begin
         // sender keeps offering, so the block backs up into req_ready
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         case (stall_cycle[8:7])
            2'd0:    rsp_ready <= 1'b1;
            2'd1:    rsp_ready <= ($urandom_range(0, 1) == 0);
            2'd2:    rsp_ready <= (stall_cycle[1:0] == 2'd0);
            default: rsp_ready <= ($urandom_range(0, 4) != 0);
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // offers one access in bursts with random gaps, returns after its transaction
   task automatic offer_access(input logic [FIELD_W-1:0] addr, input int typed_runs,
                               input logic [FIELD_W-1:0] typed_first,
                               input dir_type typed_dir);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid          <= 1'b1;
      req_access_address <= addr;
      req_typed_runs     <= typed_runs;
      req_typed_first    <= typed_first;
      req_typed_dir      <= typed_dir;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop sending and wait until every predicted prefetch has come back
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_prefetches.size() != 0) @(posedge clock);
      // an access with no run may still be in the pipe
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_degree(input logic [DEG_W-1:0] degree);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= degree;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      degree_setting = degree;
   endtask

   initial begin
      logic [PAGE_W-1:0]  hot_page [HOT_PAGES];
      int                 hot_off  [HOT_PAGES];
      int                 hot_dir  [HOT_PAGES];
      logic [FIELD_W-1:0] addr;
      logic [DEG_W-1:0]   degree;
      int                 pick;
      int                 h;
      int                 step;
      int                 next_off;

      reset              = 1'b1;
      req_valid          = 1'b0;
      req_access_address = '0;
      req_typed_runs     = UNTYPED;
      req_typed_first    = '0;
      req_typed_dir      = DIR_NONE;
      csr_write_enable   = 1'b0;
      csr_write_data     = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed table, reset degree of five until the first degree row
      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_DEGREE)
            set_degree(directed_rows[r].value[DEG_W-1:0]);
         else
            offer_access(directed_rows[r].value, directed_rows[r].typed_runs,
                         directed_rows[r].first, directed_rows[r].dir);
      end

      // a few live streams with random pages and positions
      for (int i = 0; i < HOT_PAGES; i++) begin
         hot_page[i] = PAGE_W'({$urandom, $urandom});
         hot_off[i]  = $urandom_range(0, BLOCKS_PER_PAGE - 1);
         hot_dir[i]  = ($urandom_range(0, 1) == 0) ? 1 : -1;
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       degree = DEG_W'($urandom_range(1, 15));
            1:       degree = DEG_W'(MAX_RUN);
            2:       degree = DEG_W'($urandom_range(17, 31));
            default: degree = DEG_W'($urandom_range(0, 31));
         endcase
         set_degree(degree);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            pick = $urandom_range(0, 99);
            h    = $urandom_range(0, HOT_PAGES - 1);
            if (pick < 45) begin
               // fresh page, pushed as a new tracker at the head of the table
               addr = FIELD_W'({$urandom, $urandom});
            end else if (pick < 88) begin
               // stream step: keeps its direction, turns now and then or at the page edge
               if ($urandom_range(0, 7) == 0) hot_dir[h] = -hot_dir[h];
               step     = $urandom_range(1, 3);
               next_off = hot_off[h] + hot_dir[h] * step;
               if (next_off < 0 || next_off >= BLOCKS_PER_PAGE) begin
                  hot_dir[h] = -hot_dir[h];
                  next_off   = hot_off[h] + hot_dir[h];
               end
               hot_off[h] = next_off;
               addr = {hot_page[h], OFF_W'(hot_off[h]), BLOCK_BITS'($urandom)};
            end else if (pick < 95) begin
               // same block again
               addr = {hot_page[h], OFF_W'(hot_off[h]), BLOCK_BITS'($urandom)};
            end else begin
               // stream jumps to a new page
               hot_page[h] = PAGE_W'({$urandom, $urandom});
               hot_off[h]  = $urandom_range(0, BLOCKS_PER_PAGE - 1);
               addr = {hot_page[h], OFF_W'(hot_off[h]), BLOCK_BITS'($urandom)};
            end
            offer_access(addr, UNTYPED, '0, DIR_NONE);
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/spt_pkg.sv
rtl/core/spt_cell.sv
rtl/core/spt_run.sv
rtl/core/stream_prefetch_tracker_unit.sv
rtl/core/spt_checker.sv
tb/tb_stream_prefetch_tracker_unit.sv
